>>> rtl/particle_update_engine_unit_defines.svh
// Assertion macros for the particle update engine.
// Used by the port checker; no other dependencies.
`ifndef PARTICLE_UPDATE_ENGINE_UNIT_DEFINES_SVH
`define PARTICLE_UPDATE_ENGINE_UNIT_DEFINES_SVH
// Implication checked every clock, muted during reset.
`define PUE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, muted during reset.
`define PUE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/pue_pkg.sv
// Package for the particle update engine: widths, reset values, codes.
// No dependencies.
package pue_pkg;
   localparam int SlotW   = 6;
   localparam int MaxParticles = 64;
   localparam int PosW    = 32;
   localparam int VelW    = 24;
   localparam int LifeW   = 21;
   localparam int CfgW    = 21;
   localparam int AddrW   = 2;
   localparam logic [AddrW-1:0] CSR_FRAME_US = 2'd0;
   localparam logic [AddrW-1:0] CSR_FRAME_S  = 2'd1;
   localparam logic [AddrW-1:0] CSR_GRAVITY  = 2'd2;
   localparam logic [AddrW-1:0] CSR_DRAG     = 2'd3;
   localparam logic [16:0] FRAME_US_RST = 17'd16667;
   localparam logic [16:0] FRAME_S_RST  = 17'd17476;
   localparam logic [20:0] GRAVITY_RST  = 21'd2048;
   localparam logic [16:0] DRAG_RST     = 17'd64880;
   localparam logic FUNC_SPAWN = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic             spawn;     // write spawn beat into slot
      logic             clr;       // clear-pass write of slot_idx
      logic [3:0]       stage;     // one-hot-ish compute step strobes
      logic             wb;        // write back slot
      logic             out_load;  // load output register
      logic [SlotW-1:0] slot_idx;
   } ctl_type;

   typedef struct packed {
      logic div_done;
   } sts_type;
endpackage

>>> rtl/pue_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pue_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> rtl/pue_datapath.sv
// Particle datapath: slot RAM, Euler step, lifetime ratio divider.
// Uses pue_pkg and pue_ram.
module pue_datapath #(
   parameter int Particles = pue_pkg::MaxParticles
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pue_pkg::ctl_type          ctl,
   output pue_pkg::sts_type          sts,
   input  logic [pue_pkg::PosW-1:0]  sp_x,
   input  logic [pue_pkg::PosW-1:0]  sp_y,
   input  logic [pue_pkg::VelW-1:0]  sp_vx,
   input  logic [pue_pkg::VelW-1:0]  sp_vy,
   input  logic [pue_pkg::LifeW-1:0] sp_life,
   input  logic [16:0]               frame_us,
   input  logic [16:0]               frame_s,
   input  logic signed [20:0]        gravity,
   input  logic [16:0]               drag,
   input  logic                      out_last,
   output logic [pue_pkg::SlotW-1:0] o_slot,
   output logic [pue_pkg::PosW-1:0]  o_x,
   output logic [pue_pkg::PosW-1:0]  o_y,
   output logic [7:0]                o_green,
   output logic [7:0]                o_alpha,
   output logic                      o_alive,
   output logic                      o_last
);
   localparam int AW = (Particles > 1) ? $clog2(Particles) : 1;
   localparam int RW = 2*pue_pkg::PosW + 2*pue_pkg::VelW + 2*pue_pkg::LifeW + 8;

   logic [AW-1:0] addr;
   logic          we;
   logic [RW-1:0] wdata, rdata;
   assign addr = ctl.slot_idx[AW-1:0];
   assign we   = ctl.spawn | ctl.clr | ctl.wb;

   pue_ram #(.Width(RW), .Depth(Particles)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

   // working registers of the slot in flight
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [23:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [20:0] left_ff, left_in, start_ff, start_in;
   logic [7:0]  grn_ff, grn_in;
   logic        alive_ff, alive_in;
   logic signed [42:0] prod_ff, prod_in;   // shared product register
   logic signed [42:0] prod2_ff, prod2_in;

   function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
      if (v > 44'sd8388607) return 24'sh7FFFFF;
      if (v < -44'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction
   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      if (v > 44'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -44'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // restoring divider: q = 255*left / start, 29-bit dividend
   logic [28:0] dvd_ff, dvd_in;
   logic [21:0] rem_ff, rem_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic        dbusy_ff, dbusy_in;
   logic [21:0] trial;
   assign trial = {rem_ff[20:0], dvd_ff[28]};

   logic signed [41:0] gdt;
   assign gdt = gravity * $signed({1'b0, frame_s});

   always_comb begin
      x_in = x_ff; y_in = y_ff; vx_in = vx_ff; vy_in = vy_ff;
      left_in = left_ff; start_in = start_ff; grn_in = grn_ff;
      alive_in = alive_ff; prod_in = prod_ff; prod2_in = prod2_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; dcnt_in = dcnt_ff; dbusy_in = dbusy_ff;
      if (ctl.stage[0]) begin
         // load from RAM, lifetime step, gravity product
         {x_in, y_in, vx_in, vy_in, left_in, start_in, grn_in} = rdata;
         left_in  = (left_in > {4'd0, frame_us}) ? left_in - {4'd0, frame_us} : '0;
         alive_in = left_in != '0;
         prod_in  = 43'(gdt >>> 20);
         dvd_in   = 29'({left_in, 8'd0} - {8'd0, left_in});
         rem_in   = '0; dcnt_in = '0;
         dbusy_in = alive_in && (start_in != '0);
      end
      // dead slots skip the motion steps
      if (ctl.stage[1] && alive_ff) begin
         vy_in   = sat24(44'(vy_ff) + 44'(prod_ff));
         prod_in = 43'(($signed(vx_ff) * $signed({1'b0, drag})) >>> 16);
      end
      if (ctl.stage[2] && alive_ff) begin
         vx_in    = sat24(44'(prod_ff));
         prod2_in = 43'(($signed(vy_ff) * $signed({1'b0, drag})) >>> 16);
         prod_in  = 43'(($signed(vx_in) * $signed({1'b0, frame_s})) >>> 20);
      end
      if (ctl.stage[3] && alive_ff) begin
         vy_in    = sat24(44'(prod2_ff));
         x_in     = sat32(44'(x_ff) + 44'(prod_ff));
         prod2_in = 43'(($signed(vy_in) * $signed({1'b0, frame_s})) >>> 20);
      end
      if (ctl.wb) begin
         if (alive_ff) begin
            y_in = sat32(44'(y_ff) + 44'(prod2_ff));
            grn_in = (start_ff == '0) ? 8'd0 :
                     (dvd_ff > 29'd255) ? 8'd255 : dvd_ff[7:0];
         end else begin
            x_in = x_ff;
         end
      end
      if (dbusy_ff) begin
         if (trial >= {1'b0, start_ff}) begin
            rem_in = trial - {1'b0, start_ff};
            dvd_in = {dvd_ff[27:0], 1'b1};
         end else begin
            rem_in = trial;
            dvd_in = {dvd_ff[27:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 5'd1;
         if (dcnt_ff == 5'd28) dbusy_in = 1'b0;
      end
   end

   // row written back: dead slots keep position, velocity and green
   logic [31:0] wb_y;
   logic [23:0] wb_vx, wb_vy;
   logic [7:0]  wb_g;
   assign wb_y  = y_in;
   assign wb_vx = vx_ff;
   assign wb_vy = vy_ff;
   assign wb_g  = grn_in;

   always_comb begin
      if (ctl.spawn) begin
         wdata = {sp_x, sp_y, sp_vx, sp_vy, sp_life, sp_life, 8'd255};
      end else if (ctl.clr) begin
         wdata = {{(RW-8){1'b0}}, 8'd255};
      end else begin
         wdata = {x_ff, wb_y, wb_vx, wb_vy, left_ff, start_ff, wb_g};
      end
   end

   assign sts.div_done = !dbusy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else begin
         dbusy_ff <= dbusy_in;
      end
      x_ff <= x_in; y_ff <= y_in; vx_ff <= vx_in; vy_ff <= vy_in;
      left_ff <= left_in; start_ff <= start_in; grn_ff <= grn_in;
      alive_ff <= alive_in; prod_ff <= prod_in; prod2_ff <= prod2_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in;
      if (ctl.out_load) begin
         o_slot  <= ctl.slot_idx;
         o_x     <= x_ff;
         o_y     <= wb_y;
         o_green <= wb_g;
         o_alpha <= alive_ff ? wb_g : 8'd0;
         o_alive <= alive_ff;
         o_last  <= out_last;
      end
   end
endmodule

>>> rtl/pue_ctrl.sv
// Sequencer for the particle update engine: clear pass, spawn, tick walk.
// Uses pue_pkg.
module pue_ctrl #(
   parameter int Particles = pue_pkg::MaxParticles
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_func,
   input  logic [pue_pkg::SlotW-1:0] req_slot,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pue_pkg::ctl_type          ctl,
   input  pue_pkg::sts_type          sts,
   output logic                      out_last
);
   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_C0 = 4'd3,
                          S_C1 = 4'd4, S_C2 = 4'd5, S_C3 = 4'd6, S_DIV = 4'd7,
                          S_WB = 4'd8, S_OUT = 4'd9;
   localparam logic [pue_pkg::SlotW-1:0] LastSlot = pue_pkg::SlotW'(Particles - 1);

   logic [3:0] st_ff, st_in;
   logic [pue_pkg::SlotW-1:0] idx_ff, idx_in;
   logic vld_ff, vld_in;
   logic acc;

   assign req_stall = (st_ff != S_IDLE);
   assign acc       = req_valid && !req_stall;
   assign rsp_valid = vld_ff;
   assign out_last  = (idx_ff == LastSlot);

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; vld_in = vld_ff;
      ctl = '0;
      ctl.slot_idx = idx_ff;
      if (vld_ff && !rsp_stall) vld_in = 1'b0;
      case (st_ff)
         S_CLR: begin
            ctl.clr = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LastSlot) begin
               st_in = S_IDLE; idx_in = '0;
            end
         end
         S_IDLE: begin
            if (acc) begin
               if (req_func == pue_pkg::FUNC_SPAWN) begin
                  ctl.slot_idx = req_slot;
                  ctl.spawn = ({1'b0, req_slot} < 7'(Particles));
               end else begin
                  idx_in = '0; st_in = S_RD;
               end
            end
         end
         S_RD:  st_in = S_C0;
         S_C0: begin ctl.stage = 4'b0001; st_in = S_C1; end
         S_C1: begin ctl.stage = 4'b0010; st_in = S_C2; end
         S_C2: begin ctl.stage = 4'b0100; st_in = S_C3; end
         S_C3: begin ctl.stage = 4'b1000; st_in = S_DIV; end
         S_DIV: if (sts.div_done) st_in = S_WB;
         S_WB: begin
            if (!vld_ff || !rsp_stall) begin
               ctl.wb = 1'b1; ctl.out_load = 1'b1; vld_in = 1'b1;
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (idx_ff == LastSlot) begin
               st_in = S_IDLE; idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1; st_in = S_RD;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; idx_ff <= '0; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; idx_ff <= idx_in; vld_ff <= vld_in;
      end
   end
endmodule

>>> rtl/particle_update_engine_unit.sv
// Particle update engine: spawn writes one slot; tick walks all slots once.
// Spawn: the slot is written from the request, no beat out. Tick per live slot:
// RAM read, four multiply steps, 29-step ratio divider, writeback, advance;
// dead slots skip the divider, and rsp_stall holds the writeback of any slot.
// Reset: synchronous; after reset a clearing pass over all PARTICLES slots
// zeroes the slot RAM (green 255) while req_stall is high.
module particle_update_engine_unit #(
   parameter int Particles = pue_pkg::MaxParticles
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [5:0]  req_slot,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [23:0] req_start_vx,
   input  logic signed [23:0] req_start_vy,
   input  logic [20:0] req_life_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_out_slot,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_alive,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [20:0] csr_wdata
);
   // configuration registers
   logic [16:0] frame_us_ff, frame_s_ff, drag_ff;
   logic signed [20:0] gravity_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_us_ff <= pue_pkg::FRAME_US_RST;
         frame_s_ff  <= pue_pkg::FRAME_S_RST;
         gravity_ff  <= pue_pkg::GRAVITY_RST;
         drag_ff     <= pue_pkg::DRAG_RST;
      end else if (csr_we) begin
         case (csr_index)
            pue_pkg::CSR_FRAME_US: frame_us_ff <= csr_wdata[16:0];
            pue_pkg::CSR_FRAME_S:  frame_s_ff  <= csr_wdata[16:0];
            pue_pkg::CSR_GRAVITY:  gravity_ff  <= csr_wdata;
            pue_pkg::CSR_DRAG:     drag_ff     <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   pue_pkg::ctl_type ctl;
   pue_pkg::sts_type sts;
   logic out_last;

   pue_ctrl #(.Particles(Particles)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_slot,
      .rsp_valid, .rsp_stall, .ctl, .sts, .out_last);

   pue_datapath #(.Particles(Particles)) u_dp (
      .clock, .reset, .ctl, .sts,
      .sp_x(req_start_x), .sp_y(req_start_y), .sp_vx(req_start_vx),
      .sp_vy(req_start_vy), .sp_life(req_life_us),
      .frame_us(frame_us_ff), .frame_s(frame_s_ff), .gravity(gravity_ff),
      .drag(drag_ff), .out_last,
      .o_slot(rsp_out_slot), .o_x(rsp_pos_x), .o_y(rsp_pos_y),
      .o_green(rsp_green), .o_alpha(rsp_alpha), .o_alive(rsp_alive),
      .o_last(rsp_last));
endmodule

>>> rtl/pue_checker.sv
// Port-level checker for the particle update engine, bound to the top.
// Uses particle_update_engine_unit_defines.svh.
`include "particle_update_engine_unit_defines.svh"
module pue_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_alive,
   input logic [7:0] rsp_alpha,
   input logic [7:0] rsp_green
);
   `PUE_ASSERT_IMPL(a_dead_alpha, clock, reset, rsp_valid && !rsp_alive, rsp_alpha == 8'd0, "dead slot with alpha")
   `PUE_ASSERT_IMPL(a_live_alpha, clock, reset, rsp_valid && rsp_alive, rsp_alpha == rsp_green, "alpha differs from green")
   `PUE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result beat dropped")
   `PUE_ASSERT_IMPL(a_req_stall_known, clock, reset, req_valid, !$isunknown(req_stall), "req_stall unknown")
endmodule

bind particle_update_engine_unit pue_checker u_pue_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_alive, .rsp_alpha, .rsp_green);
